/* hdl/shabs_pkg.sv */
// Shared types, constants and the rotate function of the SHA-256 byte stream hasher.
package shabs_pkg;

  typedef logic [31:0] word_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
    word_t e;
    word_t f;
    word_t g;
    word_t h;
  } work_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FINAL,
    ST_OUT
  } state_t;

  localparam logic [7:0] PAD_MARKER = 8'h80;
  localparam logic [5:0] LENGTH_POS = 6'd56;
  localparam logic [5:0] LAST_POS = 6'd63;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [1:0] LAST_INDEX = 2'd3;
  localparam logic [63:0] BITS_PER_BYTE = 64'd8;

  localparam word_t INITIAL_WORDS [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(input word_t x, input int n);
    logic [63:0] both;
    both = {x, x} >> n;
    return both[31:0];
  endfunction

endpackage

/* hdl/shabs_round.sv */
// One SHA-256 round and one message schedule step, shared by all 64 rounds.
module shabs_round (
  input  shabs_pkg::work_t v,
  input  shabs_pkg::word_t k,
  input  shabs_pkg::word_t w0,
  input  shabs_pkg::word_t w1,
  input  shabs_pkg::word_t w9,
  input  shabs_pkg::word_t w14,
  output shabs_pkg::work_t v_next,
  output shabs_pkg::word_t w_new
);

  shabs_pkg::word_t big1;
  shabs_pkg::word_t big0;
  shabs_pkg::word_t ch;
  shabs_pkg::word_t maj;
  shabs_pkg::word_t t1;
  shabs_pkg::word_t t2;
  shabs_pkg::word_t s0;
  shabs_pkg::word_t s1;

  always_comb begin
    big1 = shabs_pkg::rotr(v.e, 6) ^ shabs_pkg::rotr(v.e, 11) ^ shabs_pkg::rotr(v.e, 25);
    ch = (v.e & v.f) ^ (~v.e & v.g);
    t1 = v.h + big1 + ch + k + w0;
    big0 = shabs_pkg::rotr(v.a, 2) ^ shabs_pkg::rotr(v.a, 13) ^ shabs_pkg::rotr(v.a, 22);
    maj = (v.a & v.b) ^ (v.a & v.c) ^ (v.b & v.c);
    t2 = big0 + maj;
    v_next.h = v.g;
    v_next.g = v.f;
    v_next.f = v.e;
    v_next.e = v.d + t1;
    v_next.d = v.c;
    v_next.c = v.b;
    v_next.b = v.a;
    v_next.a = t1 + t2;
    s0 = shabs_pkg::rotr(w1, 7) ^ shabs_pkg::rotr(w1, 18) ^ (w1 >> 3);
    s1 = shabs_pkg::rotr(w14, 17) ^ shabs_pkg::rotr(w14, 19) ^ (w14 >> 10);
    w_new = s1 + w9 + s0 + w0;
  end

endmodule

/* hdl/sha256_byte_stream_hasher.sv */
// Top level: byte buffer, padding sequencer, round loop and digest output.
//
//   channel | handshake          | payload
//   --------+--------------------+-----------------------------------------
//   in      | in_valid/in_ready  | data_byte, has_byte, end_of_message
//   out     | out_valid/out_ready| digest_chunk, chunk_index, last_chunk
//
// A word that fills the 64-byte block starts 64 rounds through the one round
// unit, then the chaining word update. End of message pushes one padding
// byte per cycle up to the block end, runs one or two compressions, then
// offers four 64-bit digest chunks, each held until out_ready. Reset is
// synchronous and restores the initial chaining words; in_ready is low while
// busy.
module sha256_byte_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] digest_chunk,
  output logic [1:0]  chunk_index,
  output logic        last_chunk
);

  shabs_pkg::state_t state;
  shabs_pkg::state_t state_next;

  shabs_pkg::word_t hw [8];
  shabs_pkg::word_t w [16];
  shabs_pkg::work_t v;
  shabs_pkg::work_t v_next;
  shabs_pkg::word_t w_new;

  logic [5:0]  fill;
  logic [5:0]  round;
  logic [63:0] message_bits;
  logic [1:0]  chunk;
  logic        eom_pending;
  logic        padding;
  logic        marker_done;
  logic        length_due;

  logic        push_en;
  logic [7:0]  push_byte;
  logic [63:0] len_shifted;
  logic [7:0]  len_byte;

  shabs_round u_round (
    .v      (v),
    .k      (shabs_pkg::ROUND_K[round]),
    .w0     (w[0]),
    .w1     (w[1]),
    .w9     (w[9]),
    .w14    (w[14]),
    .v_next (v_next),
    .w_new  (w_new)
  );

  assign in_ready = (state == shabs_pkg::ST_IDLE);
  assign out_valid = (state == shabs_pkg::ST_OUT);
  assign digest_chunk = {hw[{chunk, 1'b0}], hw[{chunk, 1'b1}]};
  assign chunk_index = chunk;
  assign last_chunk = (chunk == shabs_pkg::LAST_INDEX);

  assign len_shifted = message_bits >> {3'd7 - fill[2:0], 3'b000};
  assign len_byte = len_shifted[7:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= shabs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    push_en = 1'b0;
    push_byte = data_byte;
    unique case (state)
      shabs_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (has_byte) begin
            push_en = 1'b1;
          end
          if (has_byte && fill == shabs_pkg::LAST_POS) begin
            state_next = shabs_pkg::ST_ROUND;
          end else if (end_of_message) begin
            state_next = shabs_pkg::ST_PAD;
          end
        end
      end
      shabs_pkg::ST_PAD: begin
        push_en = 1'b1;
        if (!marker_done) begin
          push_byte = shabs_pkg::PAD_MARKER;
        end else if (length_due && fill >= shabs_pkg::LENGTH_POS) begin
          push_byte = len_byte;
        end else begin
          push_byte = 8'h00;
        end
        if (fill == shabs_pkg::LAST_POS) begin
          state_next = shabs_pkg::ST_ROUND;
        end
      end
      shabs_pkg::ST_ROUND: begin
        if (round == shabs_pkg::LAST_ROUND) begin
          state_next = shabs_pkg::ST_FINAL;
        end
      end
      shabs_pkg::ST_FINAL: begin
        priority if (padding && length_due) begin
          state_next = shabs_pkg::ST_OUT;
        end else if (padding || eom_pending) begin
          state_next = shabs_pkg::ST_PAD;
        end else begin
          state_next = shabs_pkg::ST_IDLE;
        end
      end
      shabs_pkg::ST_OUT: begin
        if (out_ready && chunk == shabs_pkg::LAST_INDEX) begin
          state_next = shabs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = shabs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= {w[i][23:0], w[i + 1][31:24]};
      end
      w[15] <= {w[15][23:0], push_byte};
    end else if (state == shabs_pkg::ST_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i + 1];
      end
      w[15] <= w_new;
    end
    if (state != shabs_pkg::ST_ROUND && state_next == shabs_pkg::ST_ROUND) begin
      v <= '{hw[0], hw[1], hw[2], hw[3], hw[4], hw[5], hw[6], hw[7]};
    end else if (state == shabs_pkg::ST_ROUND) begin
      v <= v_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hw <= shabs_pkg::INITIAL_WORDS;
      fill <= '0;
      round <= '0;
      message_bits <= '0;
      chunk <= '0;
      eom_pending <= 1'b0;
      padding <= 1'b0;
      marker_done <= 1'b0;
      length_due <= 1'b0;
    end else begin
      if (push_en) begin
        fill <= fill + 6'd1;
      end
      if (state == shabs_pkg::ST_IDLE && in_valid) begin
        eom_pending <= end_of_message;
        if (has_byte) begin
          message_bits <= message_bits + shabs_pkg::BITS_PER_BYTE;
        end
      end
      if (state == shabs_pkg::ST_PAD) begin
        padding <= 1'b1;
        if (!marker_done) begin
          marker_done <= 1'b1;
          length_due <= (fill < shabs_pkg::LENGTH_POS);
        end
      end
      if (state != shabs_pkg::ST_ROUND && state_next == shabs_pkg::ST_ROUND) begin
        round <= '0;
      end else if (state == shabs_pkg::ST_ROUND) begin
        round <= round + 6'd1;
      end
      if (state == shabs_pkg::ST_FINAL) begin
        hw[0] <= hw[0] + v.a;
        hw[1] <= hw[1] + v.b;
        hw[2] <= hw[2] + v.c;
        hw[3] <= hw[3] + v.d;
        hw[4] <= hw[4] + v.e;
        hw[5] <= hw[5] + v.f;
        hw[6] <= hw[6] + v.g;
        hw[7] <= hw[7] + v.h;
        if (padding && !length_due) begin
          length_due <= 1'b1;
        end
      end
      if (state == shabs_pkg::ST_OUT && out_ready) begin
        chunk <= chunk + 2'd1;
        if (chunk == shabs_pkg::LAST_INDEX) begin
          hw <= shabs_pkg::INITIAL_WORDS;
          message_bits <= '0;
          eom_pending <= 1'b0;
          padding <= 1'b0;
          marker_done <= 1'b0;
          length_due <= 1'b0;
        end
      end
    end
  end

endmodule

/* tb/sha256_digest_checker.sv */
// Digest checker: predicts the SHA-256 digest words of accepted input words and compares.
`timescale 1ns / 100ps

module sha256_digest_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        end_of_message,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] digest_chunk,
  input  logic [1:0]  chunk_index,
  input  logic        last_chunk,
  output int          mismatches,
  output int          words_pending
);

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam int BLOCK_BYTES = 64;
  localparam int LENGTH_AT = 56;
  localparam logic [7:0] MARKER_BYTE = 8'h80;
  localparam logic [1:0] FINAL_INDEX = 2'd3;

  typedef struct {
    logic [63:0] bits;
    logic [1:0]  index;
    logic        last;
  } digest_word_t;

  logic [31:0]  hash_state [8];
  logic [7:0]   msg_block [64];
  int           block_fill;
  logic [63:0]  length_bits;
  digest_word_t digest_words_due [$];
  digest_word_t want;
  int           fail_total;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic restart_digest();
    for (int i = 0; i < 8; i++) hash_state[i] = SHA_IV[i];
    block_fill = 0;
    length_bits = 64'd0;
  endtask

  task automatic compress_block();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    for (int i = 0; i < 16; i++)
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
    e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
    for (int i = 0; i < 64; i++) begin
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
           + SHA_K[i] + w[i];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
    hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
  endtask

  task automatic absorb_byte(input logic [7:0] value);
    msg_block[block_fill] = value;
    length_bits += 64'd8;
    block_fill++;
    if (block_fill == BLOCK_BYTES) begin
      compress_block();
      block_fill = 0;
    end
  endtask

  task automatic finish_digest();
    int pos;
    digest_word_t item;
    pos = block_fill;
    msg_block[pos] = MARKER_BYTE;
    pos++;
    if (pos > LENGTH_AT) begin
      while (pos < BLOCK_BYTES) begin
        msg_block[pos] = 8'h00;
        pos++;
      end
      compress_block();
      pos = 0;
    end
    while (pos < LENGTH_AT) begin
      msg_block[pos] = 8'h00;
      pos++;
    end
    for (int k = 0; k < 8; k++) msg_block[LENGTH_AT + k] = length_bits[63 - 8*k -: 8];
    compress_block();
    for (int k = 0; k < 4; k++) begin
      item.bits = {hash_state[2*k], hash_state[2*k+1]};
      item.index = k[1:0];
      item.last = (k[1:0] == FINAL_INDEX);
      digest_words_due.push_back(item);
    end
    restart_digest();
  endtask

  initial begin
    fail_total = 0;
    mismatches = 0;
    words_pending = 0;
    restart_digest();
  end

  always @(posedge clk) begin
    if (rst) begin
      restart_digest();
      digest_words_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (digest_words_due.size() == 0) begin
          $display("%0t unexpected digest word: expected none, got %h index %0d last %0b",
                   $time, digest_chunk, chunk_index, last_chunk);
          fail_total++;
        end else begin
          want = digest_words_due.pop_front();
          if (digest_chunk !== want.bits) begin
            $display("%0t digest_chunk: expected %h, got %h", $time, want.bits, digest_chunk);
            fail_total++;
          end
          if (chunk_index !== want.index) begin
            $display("%0t chunk_index: expected %0d, got %0d", $time, want.index, chunk_index);
            fail_total++;
          end
          if (last_chunk !== want.last) begin
            $display("%0t last_chunk: expected %0b, got %0b", $time, want.last, last_chunk);
            fail_total++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (has_byte) absorb_byte(data_byte);
        if (end_of_message) finish_digest();
      end
    end
    mismatches <= fail_total;
    words_pending <= digest_words_due.size();
  end

endmodule

/* tb/tb_top.sv */
// Testbench top: clock, reset, byte stream stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps

module tb_top;

  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 200;
  localparam int WORD_TARGET = 260;
  localparam int MESSAGE_TARGET = 1;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        has_byte;
  logic        end_of_message;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] digest_chunk;
  logic [1:0]  chunk_index;
  logic        last_chunk;
  int          mismatches;
  int          words_pending;
  int          cycle_count;
  int          words_sent;
  int          messages_sent;
  bit          calm;
  int          boundary_lens [4];

  sha256_byte_stream_hasher i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_byte(data_byte),
    .has_byte(has_byte),
    .end_of_message(end_of_message),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .digest_chunk(digest_chunk),
    .chunk_index(chunk_index),
    .last_chunk(last_chunk)
  );

  sha256_digest_checker i_check (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_byte(data_byte),
    .has_byte(has_byte),
    .end_of_message(end_of_message),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .digest_chunk(digest_chunk),
    .chunk_index(chunk_index),
    .last_chunk(last_chunk),
    .mismatches(mismatches),
    .words_pending(words_pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_word(input logic [7:0] value, input logic with_byte, input logic last);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= value;
    has_byte <= with_byte;
    end_of_message <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic drain_digests();
    in_valid <= 1'b0;
    @(negedge clk);
    while (words_pending != 0) @(negedge clk);
  endtask

  task automatic send_message(input int len);
    bit tail_byte;
    tail_byte = (len > 0) && ($urandom_range(0, 1) == 1);
    calm = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 7) == 0) send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_word(8'($urandom_range(0, 255)), 1'b1, tail_byte && (i == len - 1));
    end
    if (!tail_byte) send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    messages_sent++;
    if ($urandom_range(0, 3) == 0) drain_digests();
  endtask

  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      int gap;
      gap = calm ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    int j;
    int tmp;
    rst = 1'b1;
    in_valid = 1'b0;
    data_byte = 8'h00;
    has_byte = 1'b0;
    end_of_message = 1'b0;
    cycle_count = 0;
    words_sent = 0;
    messages_sent = 0;
    calm = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty message, with a stray byte beside the end flag
    send_word(8'hff, 1'b0, 1'b1);
    send_word(8'ha5, 1'b0, 1'b0);
    send_word(8'h5a, 1'b0, 1'b0);
    send_word(8'h61, 1'b1, 1'b0);
    send_word(8'h62, 1'b1, 1'b0);
    send_word(8'h63, 1'b1, 1'b1);
    send_word(8'h00, 1'b1, 1'b0);
    send_word(8'hff, 1'b1, 1'b0);
    send_word(8'hff, 1'b0, 1'b0);
    send_word(8'hff, 1'b0, 1'b1);
    send_word(8'h80, 1'b1, 1'b1);
    send_word(8'h00, 1'b0, 1'b1);
    drain_digests();

    // padding boundaries: length field fits, spills, fills the block, full block
    boundary_lens = '{55, 56, 63, 64};
    for (int i = 3; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = boundary_lens[i];
      boundary_lens[i] = boundary_lens[j];
      boundary_lens[j] = tmp;
    end
    for (int i = 0; i < 4; i++) send_message(boundary_lens[i]);
    drain_digests();

    messages_sent = 0;
    while (words_sent < WORD_TARGET || messages_sent < MESSAGE_TARGET) begin
      if ($urandom_range(0, 3) == 0) send_message($urandom_range(0, 70));
      else send_message($urandom_range(0, 20));
    end

    drain_digests();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0 && words_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
